// ===== hw/rtl/vrt_pkg.sv =====
// shared types, constants and a helper function for the region table
package vrt_pkg;

   localparam int DEF_REGIONS   = 16;
   localparam int DEF_PAGE_BITS = 12;
   localparam int ADDR_BITS     = 48;
   localparam int FIELD_BITS    = 48;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_FREE    = 2'd1,
      OP_PROTECT = 2'd2,
      OP_QUERY   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_OVERFLOW = 3'd1,
      ST_OVERLAP  = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_OUTSIDE  = 3'd4,
      ST_FULL     = 3'd5,
      ST_ZERO     = 3'd6
   } status_type;

   typedef struct packed {
      logic present;
      logic writable;
      logic no_execute;
   } flags_type;

   typedef struct packed {
      logic                  ok;
      status_type            status;
      logic [FIELD_BITS-1:0] region_base;
      logic [FIELD_BITS-1:0] range_size;
      logic [3:0]            region_protect;
      logic                  region_committed;
      logic [3:0]            prev_protect;
      flags_type             flags;
   } rsp_type;

   function automatic flags_type prot_flags(input logic [3:0] prot);
      flags_type f;
      f = '{present: 1'b1, writable: 1'b1, no_execute: 1'b1};
      unique case (prot)
         4'd0:    f = '{present: 1'b0, writable: 1'b0, no_execute: 1'b0};
         4'd1:    f.writable = 1'b0;
         4'd3:    f = '{present: 1'b1, writable: 1'b0, no_execute: 1'b0};
         4'd4:    f.no_execute = 1'b0;
         default: f = f;
      endcase
      return f;
   endfunction

endpackage

// ===== hw/rtl/virtual_region_table.sv =====
// top level of the virtual region table
// Requests enter on req_ with the request kind (allocate, free, protect,
// query) on req_tuser, and one result leaves on rsp_ for each request. A
// request is taken when req_tvalid and req_tready are high at a clock edge;
// req_tready is high only when the block is idle and no result waits. Each
// request walks all REGIONS slots through one compare unit, one slot a
// cycle. After the accepting edge it passes the states S_PREP, S_SCAN,
// S_DEC, S_WR2 (only for a free that splits a region) and S_OUT, and
// rsp_tvalid rises as S_OUT is left. The next request is taken the cycle
// after the result has been accepted, so a new request is never taken
// while one is in progress. A stalled result is held in the output
// register with rsp_tvalid high and delays the next request by the length
// of the stall.
// Synchronous reset empties the table and drops any pending result.
module virtual_region_table #(
   parameter int REGIONS   = vrt_pkg::DEF_REGIONS,
   parameter int PAGE_BITS = vrt_pkg::DEF_PAGE_BITS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [1:0]    req_tuser,   // op
   input  logic [103:0]  req_tdata,   // address, length, protection
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [119:0]  rsp_tdata    // ok, status, region_base, range_size,
                                      // region_protect, region_committed,
                                      // prev_protect, flag_present,
                                      // flag_writable, flag_no_execute
);
   import vrt_pkg::*;

   rsp_type r;

   vrt_seq #(.REGIONS(REGIONS), .PAGE_BITS(PAGE_BITS)) u_seq (
      .clock, .reset, .req_tvalid, .req_tready,
      .req_op(op_type'(req_tuser)),
      .req_address(req_tdata[47:0]),
      .req_length(req_tdata[95:48]),
      .req_protection(req_tdata[99:96]),
      .rsp_tvalid, .rsp_tready, .rsp_data(r)
   );

   assign rsp_tdata = {8'b0, r.flags.no_execute, r.flags.writable,
                       r.flags.present, r.prev_protect, r.region_committed,
                       r.region_protect, r.range_size, r.region_base,
                       r.status, r.ok};
endmodule

// ===== hw/rtl/vrt_store.sv =====
// region slot storage with valid bits, one registered read port and one write port
module vrt_store #(
   parameter int REGIONS = vrt_pkg::DEF_REGIONS,
   parameter int PW      = 36
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [$clog2(REGIONS)-1:0] rd_idx,
   output logic                       rd_valid,
   output logic [PW-1:0]              rd_start,
   output logic [PW:0]                rd_count,
   output logic [3:0]                 rd_prot,
   input  logic                       wr_en,
   input  logic [$clog2(REGIONS)-1:0] wr_idx,
   input  logic                       wr_valid,
   input  logic [PW-1:0]              wr_start,
   input  logic [PW:0]                wr_count,
   input  logic [3:0]                 wr_prot
);
   import vrt_pkg::*;

   logic [REGIONS-1:0] valid_ff;
   logic [PW-1:0]      start_mem [REGIONS];
   logic [PW:0]        count_mem [REGIONS];
   logic [3:0]         prot_mem  [REGIONS];
   logic               rd_valid_ff;
   logic [PW-1:0]      rd_start_ff;
   logic [PW:0]        rd_count_ff;
   logic [3:0]         rd_prot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= wr_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         start_mem[wr_idx] <= wr_start;
         count_mem[wr_idx] <= wr_count;
         prot_mem[wr_idx]  <= wr_prot;
      end
      rd_valid_ff <= valid_ff[rd_idx];
      rd_start_ff <= start_mem[rd_idx];
      rd_count_ff <= count_mem[rd_idx];
      rd_prot_ff  <= prot_mem[rd_idx];
   end

   assign rd_valid = rd_valid_ff;
   assign rd_start = rd_start_ff;
   assign rd_count = rd_count_ff;
   assign rd_prot  = rd_prot_ff;

endmodule

// ===== hw/rtl/vrt_seq.sv =====
// sequencer walking the slots through one shared compare unit
module vrt_seq #(
   parameter int REGIONS   = vrt_pkg::DEF_REGIONS,
   parameter int PAGE_BITS = vrt_pkg::DEF_PAGE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  vrt_pkg::op_type       req_op,
   input  logic [47:0]           req_address,
   input  logic [47:0]           req_length,
   input  logic [3:0]            req_protection,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output vrt_pkg::rsp_type      rsp_data
);
   import vrt_pkg::*;

   localparam int PW = ADDR_BITS - PAGE_BITS;
   localparam int IW = $clog2(REGIONS);
   localparam int CW = $clog2(REGIONS + 1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_PREP  = 6'b000010,
      S_SCAN  = 6'b000100,
      S_DEC   = 6'b001000,
      S_WR2   = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   state_type    state_ff, state_in;
   op_type       op_ff;
   logic [3:0]   prot_ff;
   logic [47:0]  addr_ff;
   logic [PW:0]  bpage_ff;   // rounded base page
   logic [PW:0]  spage_ff;   // rounded size in pages
   logic [PW+1:0] epage_ff;  // end page
   logic         zero_ff, over_ff;
   logic [CW-1:0] idx_ff;
   logic         hit_ff, ovl_ff, free_ok_ff;
   logic [IW-1:0] hit_idx_ff, free_idx_ff;
   logic [PW-1:0] h_start_ff;
   logic [PW:0]   h_count_ff;
   logic [3:0]    h_prot_ff;
   rsp_type      rsp_ff, rsp_in;
   logic         rsp_valid_ff;

   logic          rd_valid;
   logic [PW-1:0] rd_start;
   logic [PW:0]   rd_count;
   logic [3:0]    rd_prot;
   logic          wr_en, wr_valid;
   logic [IW-1:0] wr_idx, rd_idx, cur_idx;
   logic [PW-1:0] wr_start;
   logic [PW:0]   wr_count;
   logic [3:0]    wr_prot;

   vrt_store #(.REGIONS(REGIONS), .PW(PW)) u_store (
      .clock, .reset, .rd_idx, .rd_valid, .rd_start, .rd_count, .rd_prot,
      .wr_en, .wr_idx, .wr_valid, .wr_start, .wr_count, .wr_prot
   );

   // read data arrives the cycle after its address, so fetch the next slot
   assign cur_idx = idx_ff[IW-1:0];
   assign rd_idx  = (state_ff == S_SCAN && idx_ff != CW'(REGIONS - 1))
                    ? IW'(idx_ff + 1'b1) : '0;

   // shared compare unit
   logic [PW+1:0] s_start, s_end, key;
   logic          in_slot, ovl_slot;
   assign s_start  = {2'b00, rd_start};
   assign s_end    = {2'b00, rd_start} + {1'b0, rd_count};
   assign key      = (op_ff == OP_QUERY) ? {2'b00, addr_ff[47:PAGE_BITS]}
                                         : {1'b0, bpage_ff};
   assign in_slot  = rd_valid && key >= s_start && key < s_end;
   assign ovl_slot = rd_valid && {1'b0, bpage_ff} < s_end && epage_ff > s_start;

   logic [PW+1:0] h_end;
   assign h_end = {2'b00, h_start_ff} + {1'b0, h_count_ff};

   logic [ADDR_BITS:0] len_r;
   assign len_r = {1'b0, req_length} + (ADDR_BITS+1)'((1 << PAGE_BITS) - 1);

   logic [47:0] base_b, size_b;
   always_comb begin
      base_b = '0;
      size_b = '0;
      base_b[ADDR_BITS-1:0] = {bpage_ff[PW-1:0], {PAGE_BITS{1'b0}}};
      size_b = 48'({spage_ff, {PAGE_BITS{1'b0}}});
   end

   always_comb begin
      state_in = state_ff;
      wr_en = 1'b0; wr_idx = hit_idx_ff; wr_valid = 1'b1;
      wr_start = h_start_ff; wr_count = h_count_ff; wr_prot = h_prot_ff;
      unique case (state_ff)
         S_IDLE: if (req_tvalid && !rsp_valid_ff) state_in = S_PREP;
         S_PREP: state_in = S_SCAN;
         S_SCAN: if (idx_ff == CW'(REGIONS - 1)) state_in = S_DEC;
         S_DEC: begin
            state_in = S_OUT;
            if (!(zero_ff || over_ff)) begin
               priority case (op_ff)
                  OP_ALLOC: if (!ovl_ff && free_ok_ff) begin
                     wr_en = 1'b1; wr_idx = free_idx_ff;
                     wr_start = bpage_ff[PW-1:0]; wr_count = spage_ff;
                     wr_prot = prot_ff;
                  end
                  OP_PROTECT: if (hit_ff && epage_ff <= h_end) begin
                     wr_en = 1'b1; wr_prot = prot_ff;
                  end
                  OP_FREE: if (hit_ff && epage_ff <= h_end) begin
                     priority if (bpage_ff[PW-1:0] == h_start_ff && epage_ff == h_end) begin
                        wr_en = 1'b1; wr_valid = 1'b0;
                     end else if (bpage_ff[PW-1:0] == h_start_ff) begin
                        wr_en = 1'b1;
                        wr_start = PW'({1'b0, h_start_ff} + spage_ff);
                        wr_count = h_count_ff - spage_ff;
                     end else if (epage_ff == h_end) begin
                        wr_en = 1'b1; wr_count = h_count_ff - spage_ff;
                     end else if (free_ok_ff) begin
                        wr_en = 1'b1;
                        wr_count = bpage_ff - {1'b0, h_start_ff};
                        state_in = S_WR2;
                     end else begin
                        wr_en = 1'b0;
                     end
                  end
                  default: wr_en = 1'b0;
               endcase
            end
         end
         S_WR2: begin
            wr_en = 1'b1; wr_idx = free_idx_ff;
            wr_start = epage_ff[PW-1:0];
            wr_count = (PW+1)'(h_end - epage_ff);
            state_in = S_OUT;
         end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_in = '0;
      if (op_ff == OP_QUERY) begin
         if (!hit_ff) rsp_in.status = ST_NOTFOUND;
         else begin
            rsp_in.ok = 1'b1;
            rsp_in.region_base = 48'({h_start_ff, {PAGE_BITS{1'b0}}});
            rsp_in.range_size = 48'({h_count_ff, {PAGE_BITS{1'b0}}});
            rsp_in.region_protect = h_prot_ff;
            rsp_in.region_committed = 1'b1;
         end
      end else if (zero_ff) rsp_in.status = ST_ZERO;
      else if (over_ff) rsp_in.status = ST_OVERFLOW;
      else if (op_ff == OP_ALLOC) begin
         if (ovl_ff) rsp_in.status = ST_OVERLAP;
         else if (!free_ok_ff) rsp_in.status = ST_FULL;
         else begin
            rsp_in.ok = 1'b1; rsp_in.region_base = base_b;
            rsp_in.range_size = size_b; rsp_in.flags = prot_flags(prot_ff);
         end
      end else if (!hit_ff) rsp_in.status = ST_NOTFOUND;
      else if (epage_ff > h_end) rsp_in.status = ST_OUTSIDE;
      else if (op_ff == OP_PROTECT) begin
         rsp_in.ok = 1'b1; rsp_in.prev_protect = h_prot_ff;
         rsp_in.flags = prot_flags(prot_ff);
      end else if (bpage_ff[PW-1:0] != h_start_ff && epage_ff != h_end
                   && !free_ok_ff) rsp_in.status = ST_FULL;
      else begin
         rsp_in.ok = 1'b1; rsp_in.region_base = base_b;
         rsp_in.range_size = size_b;
      end
   end

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_OUT) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            op_ff <= req_op; addr_ff <= req_address; prot_ff <= req_protection;
            bpage_ff <= {1'b0, req_address[ADDR_BITS-1:PAGE_BITS]};
            spage_ff <= len_r[ADDR_BITS:PAGE_BITS];
            idx_ff <= '0; hit_ff <= 1'b0; ovl_ff <= 1'b0; free_ok_ff <= 1'b0;
         end
         S_PREP: begin
            epage_ff <= {1'b0, bpage_ff} + {1'b0, spage_ff};
            zero_ff  <= (op_ff == OP_ALLOC || op_ff == OP_FREE) && spage_ff == '0;
            over_ff  <= ({1'b0, bpage_ff} + {1'b0, spage_ff}) > ((PW+2)'(1) << PW)
                        && op_ff != OP_QUERY;
         end
         S_SCAN: begin
            idx_ff <= idx_ff + 1'b1;
            if (in_slot && !hit_ff) begin
               hit_ff <= 1'b1; hit_idx_ff <= cur_idx;
               h_start_ff <= rd_start; h_count_ff <= rd_count; h_prot_ff <= rd_prot;
            end
            if (ovl_slot) ovl_ff <= 1'b1;
            if (!rd_valid && !free_ok_ff) begin
               free_ok_ff <= 1'b1; free_idx_ff <= cur_idx;
            end
         end
         S_DEC: begin
            rsp_ff <= rsp_in;
         end
         default: idx_ff <= idx_ff;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready) else $error("ready while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff) else $error("result dropped");
   a_okst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.ok == (rsp_ff.status == ST_OK))) else $error("ok/status");
endmodule
